// File: hw/rtl/json_string_unescape_assert.svh
// Assertion macros used by the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define JSU_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define JSU_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define JSU_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/jsu_pkg.sv
// Types, constants and helpers for the JSON string unescape block.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } result_t;

  // All results caused by one input word.
  typedef struct packed {
    logic [2:0]                count;
    result_t [MAX_RESULTS-1:0] res;
  } result_set_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jsu_decode.sv
// Input register, escape state and combinational decode of one source byte.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_stall,
  input  wire logic [7:0]          byte_in,
  input  wire logic                end_of_text,
  input  wire logic                free,
  output logic                     load,
  output jsu_pkg::result_set_t     set
);
  import jsu_pkg::*;

  logic        in_vld;
  logic [7:0]  in_byte;
  logic        in_eot;

  mode_t       mode, mode_next;
  logic [2:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;

  logic [4:0]  digit;
  logic        is_digit;
  logic [15:0] cp_digit, cp_sel;
  logic [1:0]  u_n;
  logic [7:0]  u_byte [3];
  logic        p_emit, p_esc, p_clear;
  result_t     p_res;

  assign src_stall = in_vld && !free;
  assign load      = in_vld && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!src_stall) begin
      in_vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      in_byte <= byte_in;
      in_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      hex_count  <= 3'd0;
      code_point <= 16'd0;
    end else if (load) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

  always_comb begin
    digit    = hex_digit(in_byte);
    is_digit = !in_eot && digit[4] && (hex_count < 3'd4);
    cp_digit = {code_point[11:0], digit[3:0]};
    cp_sel   = (mode == MODE_HEX && is_digit) ? cp_digit : code_point;
  end

  // UTF-8 encode of the code point, 1 to 3 bytes.
  always_comb begin
    u_byte[0] = 8'd0;
    u_byte[1] = 8'd0;
    u_byte[2] = 8'd0;
    if (cp_sel < 16'd128) begin
      u_n       = 2'd1;
      u_byte[0] = cp_sel[7:0];
    end else if (cp_sel < 16'd2048) begin
      u_n       = 2'd2;
      u_byte[0] = 8'hC0 | {3'd0, cp_sel[10:6]};
      u_byte[1] = 8'h80 | {2'd0, cp_sel[5:0]};
    end else begin
      u_n       = 2'd3;
      u_byte[0] = 8'hE0 | {4'd0, cp_sel[15:12]};
      u_byte[1] = 8'h80 | {2'd0, cp_sel[11:6]};
      u_byte[2] = 8'h80 | {2'd0, cp_sel[5:0]};
    end
  end

  // Handling of a byte outside any escape.
  always_comb begin
    p_emit  = 1'b1;
    p_esc   = 1'b0;
    p_clear = 1'b0;
    p_res   = '{data: in_byte, status: ST_BYTE};
    if (in_eot) begin
      p_res   = '{data: 8'd0, status: ST_UNTERM};
      p_clear = 1'b1;
    end else if (in_byte == CH_QUOTE) begin
      p_res   = '{data: 8'd0, status: ST_CLOSED};
      p_clear = 1'b1;
    end else if (in_byte == CH_BACKSLASH) begin
      p_emit = 1'b0;
      p_esc  = 1'b1;
    end
  end

  always_comb begin
    set             = '0;
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    unique case (mode)
      MODE_ESC: begin
        if (in_eot) begin
          set.count       = 3'd1;
          set.res[0]      = '{data: 8'd0, status: ST_UNTERM};
          mode_next       = MODE_PLAIN;
          hex_count_next  = 3'd0;
          code_point_next = 16'd0;
        end else begin
          mode_next = MODE_PLAIN;
          set.count = 3'd1;
          case (in_byte)
            CH_B:    set.res[0] = '{data: 8'h08, status: ST_BYTE};
            CH_F:    set.res[0] = '{data: 8'h0C, status: ST_BYTE};
            CH_N:    set.res[0] = '{data: 8'h0A, status: ST_BYTE};
            CH_R:    set.res[0] = '{data: 8'h0D, status: ST_BYTE};
            CH_T:    set.res[0] = '{data: 8'h09, status: ST_BYTE};
            CH_U: begin
              set.count       = 3'd0;
              mode_next       = MODE_HEX;
              hex_count_next  = 3'd0;
              code_point_next = 16'd0;
            end
            default: set.res[0] = '{data: in_byte, status: ST_BYTE};
          endcase
        end
      end
      MODE_HEX: begin
        if (is_digit && hex_count != 3'd3) begin
          code_point_next = cp_digit;
          hex_count_next  = hex_count + 3'd1;
        end else begin
          // Flush the code point; a non-digit then goes through plain handling.
          for (int i = 0; i < 3; i++) begin
            if (i < int'(u_n)) begin
              set.res[i] = '{data: u_byte[i], status: ST_BYTE};
            end
          end
          set.count       = {1'b0, u_n};
          mode_next       = MODE_PLAIN;
          hex_count_next  = 3'd0;
          code_point_next = 16'd0;
          if (!is_digit) begin
            if (p_emit) begin
              set.res[u_n] = p_res;
              set.count    = {1'b0, u_n} + 3'd1;
            end
            if (p_esc) begin
              mode_next = MODE_ESC;
            end
          end
        end
      end
      default: begin
        set.count  = {2'd0, p_emit};
        set.res[0] = p_res;
        if (p_esc) begin
          mode_next = MODE_ESC;
        end
        if (p_clear) begin
          mode_next       = MODE_PLAIN;
          hex_count_next  = 3'd0;
          code_point_next = 16'd0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_emit.sv
// Result register: holds the decoded words of one input and hands them out in order.
`timescale 1ns / 1ps
`default_nettype none

module jsu_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire jsu_pkg::result_set_t set,
  output logic                     free,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output logic [7:0]               byte_out,
  output logic [1:0]               status,
  output logic                     last
);
  import jsu_pkg::*;

  `include "json_string_unescape_assert.svh"

  result_t    ent [MAX_RESULTS];
  logic [2:0] rem, rem_next;
  logic       pop;

  assign res_valid = (rem != 3'd0);
  assign pop       = res_valid && !res_stall;
  // Take a new set once the final word of the current one leaves.
  assign free      = (rem == 3'd0) || (rem == 3'd1 && pop);
  assign byte_out  = ent[0].data;
  assign status    = ent[0].status;
  assign last      = (rem == 3'd1);

  always_comb begin
    rem_next = rem;
    if (load) begin
      rem_next = set.count;
    end else if (pop) begin
      rem_next = rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        ent[i] <= set.res[i];
      end
    end else if (pop) begin
      // Advance the queue by one word.
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        ent[i] <= ent[i+1];
      end
    end
  end

  `JSU_CHECK(a_rem_range, rem <= 3'd4, "result count out of range")
  `JSU_IMPLY(a_load_free, load, rem == 3'd0 || (rem == 3'd1 && pop), "load over pending words")
  `JSU_NEXT(a_more_follow, res_valid && !last, res_valid, "set ended before last word")
  `JSU_NEXT(a_pop_count, pop && !load, rem == $past(rem) - 3'd1, "pop did not retire one word")

endmodule

`default_nettype wire

// File: hw/rtl/json_string_unescape.sv
// Top level of the JSON string unescape block.
// An accepted byte passes through the input register and then the result register before its first result shows.
// Throughput: 1 byte per cycle when each byte gives at most one result and the receiver does
// not stall; a byte that gives more results holds the input while the result register drains.
// Reset: synchronous, active high; clears escape state and both valid stages.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       src_valid,
  output logic            src_stall,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_text,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [7:0]      byte_out,
  output logic [1:0]      status,
  output logic            last
);
  import jsu_pkg::*;

  result_set_t set;
  logic        load;
  logic        free;

  jsu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .byte_in     (byte_in),
    .end_of_text (end_of_text),
    .free        (free),
    .load        (load),
    .set         (set)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .set       (set),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .byte_out  (byte_out),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the JSON string unescape block.
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 450;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } decoded_t;

  // Predicts the decoded bytes and reports for each source word and checks them in order.
  class decode_board;
    mode_t       mode;
    logic [2:0]  hex_count;
    logic [15:0] code_point;
    decoded_t    decoded_q[$];
    decoded_t    fresh[$];
    int          errors;
    int          shown;

    function new();
      clear();
      errors = 0;
      shown  = 0;
    endfunction

    function void clear();
      mode       = MODE_PLAIN;
      hex_count  = 3'd0;
      code_point = 16'd0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void add(logic [7:0] d, logic [1:0] s);
      decoded_t r;
      r.data   = d;
      r.status = s;
      r.last   = 1'b0;
      fresh.push_back(r);
    endfunction

    function int hex_val(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
      return -1;
    endfunction

    // UTF-8 encode a 16-bit code point into 1 to 3 bytes.
    function void add_utf8(logic [15:0] cp);
      if (cp < 16'd128) begin
        add(cp[7:0], ST_BYTE);
      end else if (cp < 16'd2048) begin
        add({3'b110, cp[10:6]}, ST_BYTE);
        add({2'b10, cp[5:0]}, ST_BYTE);
      end else begin
        add({4'b1110, cp[15:12]}, ST_BYTE);
        add({2'b10, cp[11:6]}, ST_BYTE);
        add({2'b10, cp[5:0]}, ST_BYTE);
      end
    endfunction

    function void plain(logic [7:0] b, logic eot);
      if (eot) begin
        add(8'h00, ST_UNTERM);
        clear();
      end else if (b == CH_QUOTE) begin
        add(8'h00, ST_CLOSED);
        clear();
      end else if (b == CH_BACKSLASH) begin
        mode = MODE_ESC;
      end else begin
        add(b, ST_BYTE);
      end
    endfunction

    function void note_word(logic [7:0] b, logic eot);
      int d;
      fresh.delete();
      case (mode)
        MODE_ESC: begin
          if (eot) begin
            add(8'h00, ST_UNTERM);
            clear();
          end else begin
            mode = MODE_PLAIN;
            case (b)
              CH_B: add(8'h08, ST_BYTE);
              CH_F: add(8'h0C, ST_BYTE);
              CH_N: add(8'h0A, ST_BYTE);
              CH_R: add(8'h0D, ST_BYTE);
              CH_T: add(8'h09, ST_BYTE);
              CH_U: begin
                mode       = MODE_HEX;
                hex_count  = 3'd0;
                code_point = 16'd0;
              end
              default: add(b, ST_BYTE);
            endcase
          end
        end
        MODE_HEX: begin
          d = eot ? -1 : hex_val(b);
          if (d >= 0 && hex_count < 3'd4) begin
            code_point = {code_point[11:0], 4'(d)};
            hex_count  = hex_count + 3'd1;
            if (hex_count >= 3'd4) begin
              add_utf8(code_point);
              clear();
            end
          end else begin
            // flush digits so far, then treat the byte as plain
            add_utf8(code_point);
            clear();
            plain(b, eot);
          end
        end
        default: plain(b, eot);
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) decoded_q.push_back(fresh[i]);
    endfunction

    function void check_word(logic [7:0] d, logic [1:0] s, logic l);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: data %h status %0d last %0b", d, s, l);
        end
        return;
      end
      e = decoded_q.pop_front();
      if (e.data !== d || e.status !== s || e.last !== l) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp data %h status %0d last %0b, got data %h status %0d last %0b",
                   e.data, e.status, e.last, d, s, l);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  logic [7:0] byte_in = 8'h00;
  logic       end_of_text = 1'b0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] byte_out;
  logic [1:0] status;
  logic       last;

  decode_board board = new();
  int          idle_cycles = 0;
  int          stall_style = 0;
  int          stall_tick = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  logic [7:0]  esc_set[8] = '{CH_QUOTE, CH_BACKSLASH, 8'h2F, CH_B, CH_F, CH_N, CH_R, CH_T};

  json_string_unescape dut (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .byte_in    (byte_in),
    .end_of_text(end_of_text),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .byte_out   (byte_out),
    .status     (status),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check results, run the watchdog, and drive the receiver stall pattern.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) board.check_word(byte_out, status, last);
      if ((res_valid && !res_stall) || (src_valid && !src_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
    stall_tick <= stall_tick + 1;
    case (stall_style)
      1: res_stall <= ($urandom_range(0, 99) < 35);
      2: res_stall <= ((stall_tick % 7) < 3);
      3: res_stall <= ($urandom_range(0, 99) < 75);
      default: res_stall <= 1'b0;
    endcase
  end

  task automatic send_word(input logic [7:0] b, input logic eot);
    src_valid   <= 1'b1;
    byte_in     <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    board.note_word(b, eot);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        src_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  // Hold the source idle until every predicted result has come out.
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic send_escape();
    logic [7:0] b;
    send_word(CH_BACKSLASH, 1'b0);
    if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
    else b = esc_set[3'($urandom_range(0, 7))];
    send_word(b, 1'b0);
  endtask

  task automatic send_unicode();
    int          ndig;
    logic [15:0] cp;
    case ($urandom_range(0, 2))
      0: cp = 16'($urandom_range(0, 127));
      1: cp = 16'($urandom_range(128, 2047));
      default: cp = 16'($urandom_range(2048, 65535));
    endcase
    ndig = ($urandom_range(0, 9) < 6) ? 4 : int'($urandom_range(0, 3));
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_U, 1'b0);
    for (int i = ndig - 1; i >= 0; i--) begin
      send_word(hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
    end
  endtask

  task automatic send_token();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
      send_word(b, 1'b0);
    end else if (pick < 60) begin
      send_escape();
    end else if (pick < 80) begin
      send_unicode();
    end else if (pick < 86) begin
      send_word(CH_QUOTE, 1'b0);
    end else if (pick < 90) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [8:0] directed[$] = '{
      {1'b0, 8'h00}, {1'b0, 8'hFF},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_N},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, 8'h46}, {1'b0, 8'h66},
      {1'b0, 8'h46}, {1'b0, 8'h66},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, CH_QUOTE},
      {1'b0, CH_QUOTE},
      {1'b0, CH_BACKSLASH}, {1'b1, 8'hA5},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, 8'h41}, {1'b1, 8'h00},
      {1'b1, 8'h5A},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_BACKSLASH}
    };
    int  phase;
    bit  paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i][7:0], directed[i][8]);
    drain();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      phase       = words_sent / 75;
      stall_style = phase % 4;
      gaps_on     = (phase != 2) && (phase != 5);
      if (phase >= 3 && !paused) begin
        paused = 1'b1;
        drain();
      end
      send_token();
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_emit.sv
hw/rtl/json_string_unescape.sv
tb/tb_top.sv
